FILE: rtl/tmq_pkg.sv
// Package with shared constants, types and status codes of the typed message queue.
`timescale 1ns / 1ps
package tmq_pkg;
   localparam int MAX_MESSAGES_DEF  = 16;
   localparam int MAX_MSG_BYTES_DEF = 4096;
   localparam logic [15:0] CAPACITY_RESET = 16'd16384;

   localparam int TYPE_W = 31;
   localparam int SIZE_W = 13;
   localparam int TAG_W  = 32;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_INVALID    = 3'd1,
      ST_NO_SPACE   = 3'd2,
      ST_NO_MESSAGE = 3'd3,
      ST_TOO_BIG    = 3'd4,
      ST_FULL       = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_TAKE,
      S_SHIFT,
      S_DONE
   } state_type;
endpackage

FILE: rtl/tmq_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module tmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: rtl/typed_message_queue_top.sv
// Top level of the typed message queue: control sequencer around one entry memory.
`timescale 1ns / 1ps
// One mailbox of up to MAX_MESSAGES messages in arrival order, kept in a single
// synchronous RAM of {type, size, tag} words. A send passes through the decision
// state, which loads its result into the output register. A receive reads the
// stored entries one per cycle until it finds its message (a negative kind scans
// them all), decides in the take state, then moves each later entry down one place,
// one entry per cycle through the single RAM port, and closes the gap by lowering
// the count. One item is worked on at a time: the block returns to idle as the
// result is registered, and only then is the next accepted. A new item may be
// accepted while the previous result still waits in the output register; its own
// result is then held back until that transfer has happened.
module typed_message_queue_top #(
   parameter int MAX_MESSAGES  = tmq_pkg::MAX_MESSAGES_DEF,
   parameter int MAX_MSG_BYTES = tmq_pkg::MAX_MSG_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [15:0]                       csr_queue_capacity_bytes,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic signed [31:0]                req_msg_kind,
   input  logic [15:0]                       req_msg_size,
   input  logic [1:0]                        req_mode_flags,
   input  logic [31:0]                       req_payload_tag,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_status,
   output logic [tmq_pkg::TYPE_W-1:0]        rsp_got_type,
   output logic [tmq_pkg::SIZE_W-1:0]        rsp_got_size,
   output logic [31:0]                       rsp_got_tag,
   output logic [$clog2(MAX_MESSAGES+1)-1:0] rsp_queued_count,
   output logic [15:0]                       rsp_queued_bytes
);
   import tmq_pkg::*;

   localparam int AW = $clog2(MAX_MESSAGES);
   localparam int CW = $clog2(MAX_MESSAGES + 1);
   localparam int EW = TYPE_W + SIZE_W + TAG_W;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_MESSAGES);
   localparam logic [16:0] MAX_BYTES = 17'(MAX_MSG_BYTES);

   state_type state_ff, state_in;
   logic [15:0] cap_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0] bytes_ff, bytes_in;

   // Latched request.
   logic action_ff;
   logic signed [31:0] want_ff;
   logic [15:0] size_ff;
   logic [1:0] flags_ff;
   logic [31:0] tag_ff;

   // Scan bookkeeping.
   logic [CW-1:0] idx_ff, idx_in;     // address being issued
   logic [CW-1:0] ridx_ff, ridx_in;   // address of data now on rd_data
   logic rvalid_ff, rvalid_in;
   logic found_ff, found_in;
   logic [CW-1:0] best_ff, best_in;
   logic [TYPE_W-1:0] btype_ff, btype_in;
   logic [SIZE_W-1:0] bsize_ff, bsize_in;
   logic [TAG_W-1:0] btag_ff, btag_in;

   // Result register.
   logic rvld_ff, rvld_in;
   status_type st_ff, st_in;
   logic [TYPE_W-1:0] gtype_ff, gtype_in;
   logic [SIZE_W-1:0] gsize_ff, gsize_in;
   logic [TAG_W-1:0] gtag_ff, gtag_in;
   logic [CW-1:0] qcnt_ff, qcnt_in;
   logic [15:0] qbytes_ff, qbytes_in;

   // Memory port.
   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;
   logic [TYPE_W-1:0] r_type;
   logic [SIZE_W-1:0] r_size;
   logic [TAG_W-1:0] r_tag;

   tmq_ram #(.WIDTH(EW), .DEPTH(MAX_MESSAGES)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign {r_type, r_size, r_tag} = rd_data;

   logic req_fire, rsp_fire, out_busy;
   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rvld_ff && !rsp_stall;
   // A result still waiting at the output keeps the next one from being written.
   assign out_busy  = rvld_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAPACITY_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_queue_capacity_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff <= req_action;
         want_ff   <= req_msg_kind;
         size_ff   <= req_msg_size;
         flags_ff  <= req_mode_flags;
         tag_ff    <= req_payload_tag;
      end
      best_ff   <= best_in;
      btype_ff  <= btype_in;
      bsize_ff  <= bsize_in;
      btag_ff   <= btag_in;
      gtype_ff  <= gtype_in;
      gsize_ff  <= gsize_in;
      gtag_ff   <= gtag_in;
      qcnt_ff   <= qcnt_in;
      qbytes_ff <= qbytes_in;
      st_ff     <= st_in;
      ridx_ff   <= ridx_in;
      idx_ff    <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         bytes_ff  <= '0;
         rvalid_ff <= 1'b0;
         found_ff  <= 1'b0;
         rvld_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         bytes_ff  <= bytes_in;
         rvalid_ff <= rvalid_in;
         found_ff  <= found_in;
         rvld_ff   <= rvld_in;
      end
   end

   // Match test on the entry now read out.
   logic pos_want, neg_want, zero_want, exc;
   logic [31:0] mag;
   logic same, hit;
   logic [16:0] sum_bytes;
   always_comb begin
      zero_want = (want_ff == 32'sd0);
      neg_want  = want_ff[31];
      pos_want  = !zero_want && !neg_want;
      exc       = flags_ff[0];
      mag       = 32'(-want_ff);
      same      = ({1'b0, r_type} == want_ff[31:0]);
      hit       = exc ? !same : same;
      sum_bytes = {1'b0, size_ff} + {1'b0, bytes_ff};
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      bytes_in  = bytes_ff;
      idx_in    = idx_ff;
      ridx_in   = ridx_ff;
      rvalid_in = 1'b0;
      found_in  = found_ff;
      best_in   = best_ff;
      btype_in  = btype_ff;
      bsize_in  = bsize_ff;
      btag_in   = btag_ff;
      rvld_in   = rvld_ff && !rsp_fire;
      st_in     = st_ff;
      gtype_in  = gtype_ff;
      gsize_in  = gsize_ff;
      gtag_in   = gtag_ff;
      qcnt_in   = qcnt_ff;
      qbytes_in = qbytes_ff;
      wr_en     = 1'b0;
      wr_addr   = count_ff[AW-1:0];
      wr_data   = '0;
      rd_addr   = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_SCAN;
               idx_in   = '0;
               found_in = 1'b0;
               if (req_action) begin
                  state_in  = S_SCAN;
                  rd_addr   = '0;
                  idx_in    = CW'(1);
                  ridx_in   = '0;
                  rvalid_in = 1'b1;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            // One entry arrives per cycle; the next address is issued meanwhile.
            rd_addr = idx_ff[AW-1:0];
            if (rvalid_ff && ridx_ff < count_ff && !(found_ff && !neg_want)) begin
               if (zero_want || (pos_want && hit)) begin
                  found_in = 1'b1;
                  best_in = ridx_ff; btype_in = r_type; bsize_in = r_size; btag_in = r_tag;
               end else if (neg_want && (!found_ff || r_type < btype_ff)) begin
                  found_in = 1'b1;
                  best_in = ridx_ff; btype_in = r_type; bsize_in = r_size; btag_in = r_tag;
               end
            end
            if (rvalid_ff && ridx_ff < count_ff && !(found_ff && !neg_want)
                && !(zero_want || (pos_want && hit))
                && ridx_ff + CW'(1) < count_ff) begin
               rvalid_in = 1'b1;
               ridx_in   = idx_ff;
               idx_in    = idx_ff + CW'(1);
            end else begin
               state_in = S_TAKE;
            end
         end
         S_TAKE: begin
            if (!out_busy) begin
               gtype_in = '0; gsize_in = '0; gtag_in = '0;
               if (!found_ff || (neg_want && {1'b0, btype_ff} > mag)) begin
                  st_in = ST_NO_MESSAGE;
                  qcnt_in = count_ff; qbytes_in = bytes_ff;
                  state_in = S_IDLE; rvld_in = 1'b1;
               end else if ({3'b0, bsize_ff} > size_ff && !flags_ff[1]) begin
                  st_in = ST_TOO_BIG;
                  qcnt_in = count_ff; qbytes_in = bytes_ff;
                  state_in = S_IDLE; rvld_in = 1'b1;
               end else begin
                  st_in    = ST_OK;
                  gtype_in = btype_ff;
                  gtag_in  = btag_ff;
                  gsize_in = ({3'b0, bsize_ff} > size_ff) ? size_ff[SIZE_W-1:0] : bsize_ff;
                  bytes_in = bytes_ff - {3'b0, bsize_ff};
                  // Start moving later entries down: read best + 1.
                  idx_in    = best_ff + CW'(1);
                  rd_addr   = idx_in[AW-1:0];
                  rvalid_in = (best_ff + CW'(1) < count_ff);
                  ridx_in   = best_ff;
                  state_in  = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            if (rvalid_ff) begin
               wr_en   = 1'b1;
               wr_addr = ridx_ff[AW-1:0];
               wr_data = rd_data;
               ridx_in = idx_ff;
               idx_in  = idx_ff + CW'(1);
               rd_addr = idx_in[AW-1:0];
               rvalid_in = (idx_ff + CW'(1) < count_ff);
            end else begin
               count_in  = count_ff - CW'(1);
               qcnt_in   = count_in;
               qbytes_in = bytes_ff;
               state_in  = S_IDLE;
               rvld_in   = 1'b1;
            end
         end
         S_DONE: begin
            // Send decision.
            if (!out_busy) begin
               gtype_in = '0; gsize_in = '0; gtag_in = '0;
               if ({1'b0, size_ff} > MAX_BYTES || want_ff[31] || want_ff == 32'sd0) begin
                  st_in = ST_INVALID;
               end else if (sum_bytes > {1'b0, cap_ff}) begin
                  st_in = ST_NO_SPACE;
               end else if (count_ff >= MAX_CNT) begin
                  st_in = ST_FULL;
               end else begin
                  st_in    = ST_OK;
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  wr_data  = {want_ff[TYPE_W-1:0], size_ff[SIZE_W-1:0], tag_ff};
                  count_in = count_ff + CW'(1);
                  bytes_in = sum_bytes[15:0];
               end
               qcnt_in   = count_in;
               qbytes_in = bytes_in;
               state_in  = S_IDLE;
               rvld_in   = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid        = rvld_ff;
   assign rsp_status       = st_ff;
   assign rsp_got_type     = gtype_ff;
   assign rsp_got_size     = gsize_ff;
   assign rsp_got_tag      = gtag_ff;
   assign rsp_queued_count = qcnt_ff;
   assign rsp_queued_bytes = qbytes_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT) else $error("message count above store depth");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("item accepted while busy");
   a_ok_send_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && wr_en) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("accepted send did not add an entry");
   a_empty_no_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && count_ff == '0) |-> bytes_ff == 16'd0)
      else $error("bytes held with an empty store");
`endif
endmodule
